/* rtl/core/sse_pkg.sv */
// shared types and constants of the sorted set engine
// no dependencies; used by sse_cell, sse_chain and sorted_set_engine_top
package sse_pkg;

	localparam int CAPACITY = 1024;
	localparam int KEY_W    = 16;
	localparam int CMD_W    = 2;
	localparam int ENTRY_W  = 11;
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int IDX_W    = $clog2(CAPACITY);
	localparam int GROUP    = 32;
	localparam int NGROUPS  = (CAPACITY + GROUP - 1) / GROUP;

	localparam logic [CMD_W-1:0] CMD_QUERY  = 2'd0;
	localparam logic [CMD_W-1:0] CMD_INSERT = 2'd1;
	localparam logic [CMD_W-1:0] CMD_DELETE = 2'd2;

	// broadcast control from the sequencer to every cell
	typedef struct packed {
		logic             cmp;
		logic             ins;
		logic             del;
		logic [KEY_W-1:0] key;
		logic [CNT_W-1:0] count;
	} ctl_t;

endpackage

/* rtl/core/sse_cell.sv */
// one slot of the sorted key row: compare against the broadcast key,
// then keep, take the new key, or take a neighbor's key. depends on sse_pkg
module sse_cell (
	input  logic                        clk,
	input  logic                        arst_n,
	input  sse_pkg::ctl_t               ctl,
	input  logic [sse_pkg::IDX_W-1:0]   idx,
	input  logic                        lt_left,
	input  logic [sse_pkg::KEY_W-1:0]   key_left,
	input  logic [sse_pkg::KEY_W-1:0]   key_right,
	output logic                        lt,
	output logic                        eq,
	output logic [sse_pkg::KEY_W-1:0]   key_out
);

	logic [sse_pkg::KEY_W-1:0] key_q;
	logic                      lt_q;
	logic                      occ;

	assign occ     = sse_pkg::CNT_W'(idx) < ctl.count;
	assign eq      = occ && (key_q == ctl.key);
	assign lt      = lt_q;
	assign key_out = key_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lt_q <= 1'b0;
		end else if (ctl.cmp) begin
			lt_q <= occ && (key_q < ctl.key);
		end
	end

	// insert: the first slot not below the key takes it, later slots shift up
	// delete: every slot not below the key takes its right neighbor
	always_ff @(posedge clk) begin
		if (ctl.ins && !lt_q) begin
			key_q <= lt_left ? ctl.key : key_left;
		end else if (ctl.del && !lt_q) begin
			key_q <= key_right;
		end
	end

endmodule

/* rtl/core/sse_chain.sv */
// row of sse_cell slots linked to their neighbors, plus one registered
// match flag per group of slots. depends on sse_pkg and sse_cell
module sse_chain (
	input  logic                          clk,
	input  logic                          arst_n,
	input  sse_pkg::ctl_t                 ctl,
	output logic [sse_pkg::NGROUPS-1:0]   grp_hit
);

	localparam int PAD = sse_pkg::NGROUPS * sse_pkg::GROUP;

	logic [sse_pkg::CAPACITY-1:0] lt;
	logic [PAD-1:0]               eq_pad;
	logic [sse_pkg::KEY_W-1:0]    keys [sse_pkg::CAPACITY];
	logic [sse_pkg::NGROUPS-1:0]  grp_q;

	genvar i;
	generate
		for (i = 0; i < sse_pkg::CAPACITY; i++) begin : g_cell
			logic                      lt_l;
			logic [sse_pkg::KEY_W-1:0] key_l;
			logic [sse_pkg::KEY_W-1:0] key_r;
			if (i == 0) begin : g_first
				// nothing to the left: slot 0 takes the key if not below it
				assign lt_l  = 1'b1;
				assign key_l = '0;
			end else begin : g_mid
				assign lt_l  = lt[i-1];
				assign key_l = keys[i-1];
			end
			if (i == sse_pkg::CAPACITY - 1) begin : g_last
				assign key_r = '0;
			end else begin : g_notlast
				assign key_r = keys[i+1];
			end
			sse_cell u_cell (
				.clk       (clk),
				.arst_n    (arst_n),
				.ctl       (ctl),
				.idx       (sse_pkg::IDX_W'(i)),
				.lt_left   (lt_l),
				.key_left  (key_l),
				.key_right (key_r),
				.lt        (lt[i]),
				.eq        (eq_pad[i]),
				.key_out   (keys[i])
			);
		end
		if (PAD > sse_pkg::CAPACITY) begin : g_pad
			assign eq_pad[PAD-1:sse_pkg::CAPACITY] = '0;
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grp_q <= '0;
		end else if (ctl.cmp) begin
			for (int g = 0; g < sse_pkg::NGROUPS; g++) begin
				grp_q[g] <= |eq_pad[g*sse_pkg::GROUP +: sse_pkg::GROUP];
			end
		end
	end

	assign grp_hit = grp_q;

endmodule

/* rtl/core/sorted_set_engine_top.sv */
// sorted set engine: ordered set of distinct 16-bit keys
// sequencer, key count and result word; depends on sse_pkg and sse_chain
//
// usage:
//  - a command word (cmd, key) is taken at a rising edge with start high and
//    busy low. cmd 0 queries, 1 inserts, 2 deletes; 3 does nothing
//  - each command gives exactly one result word: done is high for one cycle
//    with succeeded, store_full and entry_count; the receiver cannot stall,
//    so the word must be taken in that cycle
//  - the result word is registered in the apply step; busy is high from the
//    accepting edge until done, so a new command waits for the last result
//  - the steps are: every cell compares its key, the match flags are ored
//    per group of 32 cells, the group flags are ored, then the row shifts
//    and the count moves in the same cycle
//  - a new command may be accepted in the cycle where done is high
//  - reset empties the set at once (count to zero); stored keys are left
//    as they are and only slots below the count are ever looked at
module sorted_set_engine_top (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  logic [sse_pkg::CMD_W-1:0]    cmd,
	input  logic [sse_pkg::KEY_W-1:0]    key,
	output logic                         done,
	output logic                         succeeded,
	output logic                         store_full,
	output logic [sse_pkg::ENTRY_W-1:0]  entry_count
);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_CMP   = 2'd1;
	localparam logic [1:0] ST_RED   = 2'd2;
	localparam logic [1:0] ST_APPLY = 2'd3;

	logic [1:0]                  state_q;
	logic [sse_pkg::CMD_W-1:0]   cmd_q;
	logic [sse_pkg::KEY_W-1:0]   key_q;
	logic [sse_pkg::CNT_W-1:0]   count_q;
	logic [sse_pkg::CNT_W-1:0]   count_nxt;
	logic                        found_q;
	logic [sse_pkg::NGROUPS-1:0] grp_hit;
	logic                        has_room;
	logic                        do_ins;
	logic                        do_del;
	logic                        refuse;
	logic                        ok;
	logic                        done_q;
	logic                        succ_q;
	logic                        full_q;
	logic [sse_pkg::ENTRY_W-1:0] entry_q;
	sse_pkg::ctl_t               ctl;

	assign busy     = (state_q != ST_IDLE);
	assign has_room = count_q < sse_pkg::CNT_W'(sse_pkg::CAPACITY);

	always_comb begin
		do_ins = (cmd_q == sse_pkg::CMD_INSERT) && !found_q && has_room;
		refuse = (cmd_q == sse_pkg::CMD_INSERT) && !found_q && !has_room;
		do_del = (cmd_q == sse_pkg::CMD_DELETE) && found_q;
		ok     = do_ins || do_del || ((cmd_q == sse_pkg::CMD_QUERY) && found_q);
		if (do_ins) begin
			count_nxt = count_q + sse_pkg::CNT_W'(1);
		end else if (do_del) begin
			count_nxt = count_q - sse_pkg::CNT_W'(1);
		end else begin
			count_nxt = count_q;
		end
	end

	always_comb begin
		ctl.cmp   = (state_q == ST_CMP);
		ctl.ins   = (state_q == ST_APPLY) && do_ins;
		ctl.del   = (state_q == ST_APPLY) && do_del;
		ctl.key   = key_q;
		ctl.count = count_q;
	end

	sse_chain u_chain (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (ctl),
		.grp_hit (grp_hit)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cmd_q   <= sse_pkg::CMD_QUERY;
			key_q   <= '0;
			count_q <= '0;
			found_q <= 1'b0;
			done_q  <= 1'b0;
			succ_q  <= 1'b0;
			full_q  <= 1'b0;
			entry_q <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						cmd_q   <= cmd;
						key_q   <= key;
						state_q <= ST_CMP;
					end
				end
				ST_CMP: begin
					state_q <= ST_RED;
				end
				ST_RED: begin
					found_q <= |grp_hit;
					state_q <= ST_APPLY;
				end
				ST_APPLY: begin
					count_q <= count_nxt;
					done_q  <= 1'b1;
					succ_q  <= ok;
					full_q  <= refuse;
					entry_q <= sse_pkg::ENTRY_W'(count_nxt);
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign done        = done_q;
	assign succeeded   = succ_q;
	assign store_full  = full_q;
	assign entry_count = entry_q;

	a_done_after_apply: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(state_q) == ST_APPLY)
		else $error("result word without an apply step");

	a_count_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= sse_pkg::CNT_W'(sse_pkg::CAPACITY))
		else $error("key count above capacity");

	a_full_not_ok: assert property (@(posedge clk) disable iff (!arst_n)
		store_full |-> !succeeded)
		else $error("refused insert flagged as success");

	a_accept_to_cmp: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> state_q == ST_CMP)
		else $error("accepted word did not start a compare");

	a_count_moves_on_apply: assert property (@(posedge clk) disable iff (!arst_n)
		count_q != $past(count_q) |-> $past(state_q) == ST_APPLY && done)
		else $error("key count changed outside an apply step");

endmodule
